>>> rtl/sdcd_pkg.sv
package sdcd_pkg;

   localparam int SERIAL_W  = 17;
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int REM_W     = 9;
   localparam int MAX_YEARS = 256;
   localparam int MONTHS    = 12;
   localparam int STEP_W    = 3;

   typedef logic [STEP_W-1:0] step_type;

   // Program addresses of the control store
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_YEAR  = 3'd1;
   localparam step_type STEP_REM   = 3'd2;
   localparam step_type STEP_MONTH = 3'd3;
   localparam step_type STEP_EMIT  = 3'd4;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_YEAR_BIT,
      OP_REM,
      OP_MONTH_BIT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CNT_MORE,
      COND_OUT_BUSY
   } cond_type;

   // Jump to jump_to when cond holds, else go to next_to
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_to;
      step_type next_to;
   } ctrl_word_type;

   typedef struct packed {
      logic cnt_more;
      logic out_busy;
   } status_type;

   function automatic logic is_leap(int y);
      if ((y % 4) != 0) begin
         return 1'b0;
      end
      if ((y % 100) != 0) begin
         return 1'b1;
      end
      return ((y % 400) == 0);
   endfunction

   // Day count at the start of each supported year, packed SERIAL_W bits a year
   function automatic logic [MAX_YEARS*SERIAL_W-1:0] build_starts(int first, int count);
      logic [MAX_YEARS*SERIAL_W-1:0] v;
      int acc;
      int i;
      v   = '0;
      acc = 0;
      for (i = 0; i < MAX_YEARS; i++) begin
         if (i < count) begin
            v[i*SERIAL_W +: SERIAL_W] = SERIAL_W'(acc);
         end
         acc = acc + (is_leap(first + i) ? 366 : 365);
      end
      return v;
   endfunction

   function automatic logic [MAX_YEARS-1:0] build_leaps(int first, int count);
      logic [MAX_YEARS-1:0] v;
      int i;
      v = '0;
      for (i = 0; i < MAX_YEARS; i++) begin
         if (i < count) begin
            v[i] = is_leap(first + i);
         end
      end
      return v;
   endfunction

   function automatic int total_days(int first, int count);
      int acc;
      int i;
      acc = 0;
      for (i = 0; i < count; i++) begin
         acc = acc + (is_leap(first + i) ? 366 : 365);
      end
      return acc;
   endfunction

   function automatic logic [REM_W-1:0] month_start(logic leap, logic [MONTH_W-1:0] k);
      logic [REM_W-1:0] s;
      case (k)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = leap ? 9'd60  : 9'd59;
         4'd3:    s = leap ? 9'd91  : 9'd90;
         4'd4:    s = leap ? 9'd121 : 9'd120;
         4'd5:    s = leap ? 9'd152 : 9'd151;
         4'd6:    s = leap ? 9'd182 : 9'd181;
         4'd7:    s = leap ? 9'd213 : 9'd212;
         4'd8:    s = leap ? 9'd244 : 9'd243;
         4'd9:    s = leap ? 9'd274 : 9'd273;
         4'd10:   s = leap ? 9'd305 : 9'd304;
         4'd11:   s = leap ? 9'd335 : 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/sdcd_ucode_rom.sv
module sdcd_ucode_rom (
   input  sdcd_pkg::step_type      pc,
   output sdcd_pkg::ctrl_word_type ctrl
);

   always_comb begin
      unique case (pc)
         sdcd_pkg::STEP_IDLE: begin
            ctrl = '{sdcd_pkg::OP_LOAD, sdcd_pkg::COND_NO_REQ,
                     sdcd_pkg::STEP_IDLE, sdcd_pkg::STEP_YEAR};
         end
         sdcd_pkg::STEP_YEAR: begin
            ctrl = '{sdcd_pkg::OP_YEAR_BIT, sdcd_pkg::COND_CNT_MORE,
                     sdcd_pkg::STEP_YEAR, sdcd_pkg::STEP_REM};
         end
         sdcd_pkg::STEP_REM: begin
            ctrl = '{sdcd_pkg::OP_REM, sdcd_pkg::COND_ALWAYS,
                     sdcd_pkg::STEP_MONTH, sdcd_pkg::STEP_MONTH};
         end
         sdcd_pkg::STEP_MONTH: begin
            ctrl = '{sdcd_pkg::OP_MONTH_BIT, sdcd_pkg::COND_CNT_MORE,
                     sdcd_pkg::STEP_MONTH, sdcd_pkg::STEP_EMIT};
         end
         sdcd_pkg::STEP_EMIT: begin
            ctrl = '{sdcd_pkg::OP_EMIT, sdcd_pkg::COND_OUT_BUSY,
                     sdcd_pkg::STEP_EMIT, sdcd_pkg::STEP_IDLE};
         end
         default: begin
            ctrl = '{sdcd_pkg::OP_NOP, sdcd_pkg::COND_ALWAYS,
                     sdcd_pkg::STEP_IDLE, sdcd_pkg::STEP_IDLE};
         end
      endcase
   end

endmodule

>>> rtl/sdcd_datapath.sv
module sdcd_datapath #(
   parameter int BASE_YEAR  = 1900,
   parameter int YEAR_COUNT = 200
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sdcd_pkg::ctrl_word_type          ctrl,
   input  logic                             req_valid,
   input  logic [sdcd_pkg::SERIAL_W-1:0]    req_serial_day,
   input  logic                             rsp_stall,
   output sdcd_pkg::status_type             status,
   output logic                             rsp_valid,
   output logic [sdcd_pkg::YEAR_W-1:0]      rsp_year,
   output logic [sdcd_pkg::MONTH_W-1:0]     rsp_month,
   output logic [sdcd_pkg::DAY_W-1:0]       rsp_day,
   output logic                             rsp_out_of_range
);

   localparam int YW = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1;
   localparam int CW = ($clog2(YW) > 2) ? $clog2(YW) : 2;
   localparam int SW = sdcd_pkg::SERIAL_W;

   localparam logic [sdcd_pkg::MAX_YEARS*SW-1:0] STARTS =
      sdcd_pkg::build_starts(BASE_YEAR, YEAR_COUNT);
   localparam logic [sdcd_pkg::MAX_YEARS-1:0] LEAPS =
      sdcd_pkg::build_leaps(BASE_YEAR, YEAR_COUNT);
   localparam logic [SW-1:0] TOTAL =
      SW'(sdcd_pkg::total_days(BASE_YEAR, YEAR_COUNT));
   localparam logic [YW:0] YCOUNT = (YW+1)'(YEAR_COUNT);
   localparam logic [CW-1:0] YEAR_TOP = CW'(YW - 1);
   localparam logic [CW-1:0] MONTH_TOP = CW'(3);
   localparam logic [sdcd_pkg::MONTH_W-1:0] MCOUNT = 4'(sdcd_pkg::MONTHS);

   logic [SW-1:0]                    serial_ff, serial_in;
   logic                             oor_ff, oor_in;
   logic [YW-1:0]                    idx_ff, idx_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [sdcd_pkg::MONTH_W-1:0]     m_ff, m_in;
   logic [sdcd_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic                             leap_ff, leap_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sdcd_pkg::YEAR_W-1:0]      rsp_year_ff, rsp_year_in;
   logic [sdcd_pkg::MONTH_W-1:0]     rsp_month_ff, rsp_month_in;
   logic [sdcd_pkg::DAY_W-1:0]       rsp_day_ff, rsp_day_in;
   logic                             rsp_oor_ff, rsp_oor_in;

   logic [YW-1:0]                    ycand;
   logic [SW-1:0]                    ycand_start;
   logic [SW-1:0]                    ysel_start;
   logic [sdcd_pkg::MONTH_W-1:0]     mcand;
   logic [sdcd_pkg::REM_W-1:0]       mcand_start;
   logic [sdcd_pkg::REM_W-1:0]       msel_start;
   logic                             out_busy;
   logic                             emit;

   assign out_busy    = rsp_valid_ff & rsp_stall;
   assign emit        = (ctrl.op == sdcd_pkg::OP_EMIT) & ~out_busy;
   assign ycand       = idx_ff | (YW'(1) << cnt_ff);
   assign ycand_start = STARTS[int'(ycand)*SW +: SW];
   assign ysel_start  = STARTS[int'(idx_ff)*SW +: SW];
   assign mcand       = m_ff | (4'd1 << cnt_ff[1:0]);
   assign mcand_start = sdcd_pkg::month_start(leap_ff, mcand);
   assign msel_start  = sdcd_pkg::month_start(leap_ff, m_ff);

   always_comb begin
      serial_in    = serial_ff;
      oor_in       = oor_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      rem_in       = rem_ff;
      leap_in      = leap_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (ctrl.op)
         sdcd_pkg::OP_LOAD: begin
            if (req_valid) begin
               serial_in = req_serial_day;
               oor_in    = (req_serial_day >= TOTAL);
               idx_in    = '0;
               cnt_in    = YEAR_TOP;
            end
         end
         sdcd_pkg::OP_YEAR_BIT: begin
            // keep the candidate bit if that year is supported and starts at or below the serial
            if (({1'b0, ycand} < YCOUNT) && (ycand_start <= serial_ff)) begin
               idx_in = ycand;
            end
            cnt_in = cnt_ff - CW'(1);
         end
         sdcd_pkg::OP_REM: begin
            rem_in  = sdcd_pkg::REM_W'(serial_ff - ysel_start);
            leap_in = LEAPS[idx_ff];
            m_in    = '0;
            cnt_in  = MONTH_TOP;
         end
         sdcd_pkg::OP_MONTH_BIT: begin
            if ((mcand < MCOUNT) && (mcand_start <= rem_ff)) begin
               m_in = mcand;
            end
            cnt_in = cnt_ff - CW'(1);
         end
         sdcd_pkg::OP_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_oor_in   = oor_ff;
               if (oor_ff) begin
                  rsp_year_in  = '0;
                  rsp_month_in = '0;
                  rsp_day_in   = '0;
               end else begin
                  rsp_year_in  = sdcd_pkg::YEAR_W'(BASE_YEAR + int'(idx_ff));
                  rsp_month_in = m_ff + 4'd1;
                  rsp_day_in   = sdcd_pkg::DAY_W'(rem_ff - msel_start + 9'd1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      serial_ff    <= serial_in;
      oor_ff       <= oor_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      m_ff         <= m_in;
      rem_ff       <= rem_in;
      leap_ff      <= leap_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign status.cnt_more  = (cnt_ff != '0);
   assign status.out_busy  = out_busy;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day          = rsp_day_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

>>> rtl/serial_day_to_calendar_date.sv
// Serial day count to Gregorian year, month and day.
// Request channel: req_valid / req_stall with req_serial_day, where 0 is
// 1 January of BASE_YEAR. Response channel: rsp_valid / rsp_stall with
// rsp_year, rsp_month, rsp_day and rsp_out_of_range. An item moves on an
// edge where valid is high and stall is low. One response per request.
// A serial at or past the end of the last of YEAR_COUNT years gives
// rsp_out_of_range high and zero year, month and day.
// The accepting edge is the load step; then follow YW year-search steps,
// where YW = ceil(log2(YEAR_COUNT)) (one bit of the year index per step),
// one remainder step, four month-search steps and one output step,
// sequenced by a small control store. A new item is taken only once the
// control store is back at its idle step after the output step.
// req_stall is high while an item is in work.
// A finished item waits in the output register while rsp_stall is high;
// the block meanwhile accepts and works on the next item, and holds it at
// the output step until the register frees.
// Reset clears the step counter and the response valid; no other state.
module serial_day_to_calendar_date #(
   parameter int BASE_YEAR  = 1900,
   parameter int YEAR_COUNT = 200
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sdcd_pkg::SERIAL_W-1:0]    req_serial_day,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sdcd_pkg::YEAR_W-1:0]      rsp_year,
   output logic [sdcd_pkg::MONTH_W-1:0]     rsp_month,
   output logic [sdcd_pkg::DAY_W-1:0]       rsp_day,
   output logic                             rsp_out_of_range
);

   sdcd_pkg::step_type      pc_ff, pc_in;
   sdcd_pkg::ctrl_word_type ctrl;
   sdcd_pkg::status_type    status;
   logic                    cond_true;

   sdcd_ucode_rom u_rom (
      .pc   (pc_ff),
      .ctrl (ctrl)
   );

   sdcd_datapath #(
      .BASE_YEAR  (BASE_YEAR),
      .YEAR_COUNT (YEAR_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_valid        (req_valid),
      .req_serial_day   (req_serial_day),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always_comb begin
      unique case (ctrl.cond)
         sdcd_pkg::COND_ALWAYS:   cond_true = 1'b1;
         sdcd_pkg::COND_NO_REQ:   cond_true = ~req_valid;
         sdcd_pkg::COND_CNT_MORE: cond_true = status.cnt_more;
         sdcd_pkg::COND_OUT_BUSY: cond_true = status.out_busy;
         default:                 cond_true = 1'b1;
      endcase
   end

   assign pc_in     = cond_true ? ctrl.jump_to : ctrl.next_to;
   assign req_stall = (pc_ff != sdcd_pkg::STEP_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sdcd_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Out-of-range items carry an all-zero date
   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_year == '0 && rsp_month == '0 && rsp_day == '0))
      else $error("out-of-range item carries a date");

   a_date_sane : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |->
         (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1))
      else $error("month or day outside calendar range");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not busy after accepting an item");

   a_emit_from_output_step : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && $past(!reset)) |=> (!rsp_valid || $past(pc_ff) == sdcd_pkg::STEP_EMIT))
      else $error("response raised outside the output step");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int BASE_YEAR      = 1900;
   localparam int YEAR_COUNT     = 200;
   localparam int SERIAL_MAX     = (1 << sdcd_pkg::SERIAL_W) - 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 25;

   typedef struct packed {
      logic [sdcd_pkg::YEAR_W-1:0]  year;
      logic [sdcd_pkg::MONTH_W-1:0] month;
      logic [sdcd_pkg::DAY_W-1:0]   day;
      logic                         out_of_range;
   } cal_date_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [sdcd_pkg::SERIAL_W-1:0] req_serial_day = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [sdcd_pkg::YEAR_W-1:0]   rsp_year;
   logic [sdcd_pkg::MONTH_W-1:0]  rsp_month;
   logic [sdcd_pkg::DAY_W-1:0]    rsp_day;
   logic                          rsp_out_of_range;

   cal_date_type pending_dates[$];
   cal_date_type want_date;
   bit           steady_flow = 1'b0;
   int           mismatches = 0;
   int           items_sent = 0;
   int           dates_checked = 0;
   int           beyond_range_seen = 0;
   int           leap_days_seen = 0;
   int           quiet_cycles = 0;

   serial_day_to_calendar_date #(
      .BASE_YEAR(BASE_YEAR),
      .YEAR_COUNT(YEAR_COUNT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_serial_day  (req_serial_day),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_year        (rsp_year),
      .rsp_month       (rsp_month),
      .rsp_day         (rsp_day),
      .rsp_out_of_range(rsp_out_of_range)
   );

   always #5 clock = ~clock;

   function automatic bit has_feb29(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_before_year(input int y);
      int acc;
      int yy;
      acc = 0;
      for (yy = BASE_YEAR; yy < y; yy++) begin
         acc = acc + (has_feb29(yy) ? 366 : 365);
      end
      return acc;
   endfunction

   // Day of year on which month k (0 = January) begins
   function automatic int month_offset(input bit leap, input int k);
      int base;
      case (k)
         0:       base = 0;
         1:       base = 31;
         2:       base = 59;
         3:       base = 90;
         4:       base = 120;
         5:       base = 151;
         6:       base = 181;
         7:       base = 212;
         8:       base = 243;
         9:       base = 273;
         10:      base = 304;
         default: base = 334;
      endcase
      return base + ((leap && k >= 2) ? 1 : 0);
   endfunction

   function automatic cal_date_type serial_to_date(
      input logic [sdcd_pkg::SERIAL_W-1:0] serial);
      cal_date_type d;
      int           first_day;
      int           len;
      int           rem;
      int           m;
      int           i;
      int           k;
      bit           leap;
      d              = '0;
      d.out_of_range = 1'b1;
      first_day      = 0;
      for (i = 0; i < YEAR_COUNT; i++) begin
         leap = has_feb29(BASE_YEAR + i);
         len  = leap ? 366 : 365;
         if (d.out_of_range && int'(serial) < first_day + len) begin
            rem = int'(serial) - first_day;
            m   = 0;
            for (k = 1; k < 12; k++) begin
               if (month_offset(leap, k) <= rem) begin
                  m = k;
               end
            end
            d.year         = sdcd_pkg::YEAR_W'(BASE_YEAR + i);
            d.month        = sdcd_pkg::MONTH_W'(m + 1);
            d.day          = sdcd_pkg::DAY_W'(rem - month_offset(leap, m) + 1);
            d.out_of_range = 1'b0;
         end
         first_day = first_day + len;
      end
      return d;
   endfunction

   // Call just after a rising edge; leaves valid high once the item is taken
   task automatic send_serial(input int serial);
      while (!steady_flow && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_serial_day <= sdcd_pkg::SERIAL_W'(serial);
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_dates.push_back(serial_to_date(sdcd_pkg::SERIAL_W'(serial)));
      items_sent++;
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_calendar_edges();
      int span;
      span = days_before_year(BASE_YEAR + YEAR_COUNT);
      send_serial(0);
      send_serial(1);
      send_serial(31);
      send_serial(58);
      send_serial(59);                                // 1900 has no 29 February
      send_serial(364);
      send_serial(365);
      send_serial(days_before_year(1904) + 59);       // 29 February 1904
      send_serial(days_before_year(1904) + 365);
      send_serial(days_before_year(1950) + 334);
      send_serial(days_before_year(1960) + 335);
      send_serial(days_before_year(2000) + 59);       // 2000 is a leap century
      send_serial(days_before_year(2000) + 60);
      send_serial(days_before_year(2000) + 365);
      send_serial(days_before_year(2099) - 1);
      send_serial(span - 1);                          // last supported day
      send_serial(span);                              // first day past the range
      send_serial(span + 1);
      send_serial(65535);
      send_serial(65536);
      send_serial('h0AAAA);
      send_serial('h15555);
      send_serial(SERIAL_MAX);
   endtask

   task automatic test_mixed_dates(input int count);
      int span;
      int serial;
      int n;
      int roll;
      span = days_before_year(BASE_YEAR + YEAR_COUNT);
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            serial = $urandom_range(SERIAL_MAX, span);
         end else if (roll < 40) begin
            // land on or next to a year or month boundary
            serial = days_before_year(BASE_YEAR + $urandom_range(YEAR_COUNT - 1));
            case ($urandom_range(9))
               0:       serial = serial - 1;
               1:       serial = serial + 1;
               2:       serial = serial + 30;
               3:       serial = serial + 31;
               4:       serial = serial + 58;
               5:       serial = serial + 59;
               6:       serial = serial + 60;
               7:       serial = serial + 364;
               8:       serial = serial + 365;
               default: serial = serial + 0;
            endcase
            if (serial < 0) begin
               serial = 0;
            end
         end else begin
            serial = $urandom_range(span - 1, 0);
         end
         send_serial(serial);
      end
   endtask

   task automatic test_back_to_back(input int count);
      steady_flow = 1'b1;
      test_mixed_dates(count);
      steady_flow = 1'b0;
   endtask

   task automatic test_drain_pause();
      drain_pending();
      test_mixed_dates(20);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_dates.size() == 0) begin
               $error("unexpected response: year %0d month %0d day %0d out_of_range %0b",
                      rsp_year, rsp_month, rsp_day, rsp_out_of_range);
               mismatches++;
            end else begin
               want_date = pending_dates.pop_front();
               dates_checked++;
               if (want_date.out_of_range) begin
                  beyond_range_seen++;
               end
               if (want_date.month == 2 && want_date.day == 29) begin
                  leap_days_seen++;
               end
               if (rsp_year !== want_date.year) begin
                  $error("year: expected %0d, got %0d", want_date.year, rsp_year);
                  mismatches++;
               end
               if (rsp_month !== want_date.month) begin
                  $error("month: expected %0d, got %0d", want_date.month, rsp_month);
                  mismatches++;
               end
               if (rsp_day !== want_date.day) begin
                  $error("day: expected %0d, got %0d", want_date.day, rsp_day);
                  mismatches++;
               end
               if (rsp_out_of_range !== want_date.out_of_range) begin
                  $error("out_of_range: expected %0b, got %0b",
                         want_date.out_of_range, rsp_out_of_range);
                  mismatches++;
               end
            end
         end
         rsp_stall <= !steady_flow && ($urandom_range(99) < 14);
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, pending_dates.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_calendar_edges();
      test_mixed_dates(300);
      test_drain_pause();
      test_back_to_back(200);
      test_mixed_dates(280);
      drain_pending();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("converted %0d serial days, %0d responses checked", items_sent, dates_checked);
      $display("covered %0d past-range serials and %0d leap days, with and without stalls",
               beyond_range_seen, leap_days_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
